// ----- sv/fgbi_pkg.sv -----
// Shared types, field widths and codes for the feature grid bucket index.
`timescale 1ns / 1ps

package fgbi_pkg;

    localparam int MODE_W    = 2;
    localparam int COORD_W   = 12;
    localparam int INDEX_W   = 10;
    localparam int RADIUS_W  = 11;
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;
    localparam int RECIP_W   = 13;
    localparam int QUO_W     = 14;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED  = 3'd0,
        ST_OUTSIDE = 3'd1,
        ST_FULL    = 3'd2,
        ST_HIT     = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_TRUNC   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC1,
        S_CALC2,
        S_CALC3,
        S_DECIDE,
        S_INS_OUTSIDE,
        S_INS_FILL,
        S_Q_ADDR,
        S_Q_FILL,
        S_Q_SLOT,
        S_Q_SADDR,
        S_Q_END,
        S_Q_TRUNC
    } state_t;

    typedef struct packed {
        logic    load;
        logic    clr_rst;
        logic    clr_step;
        logic    init_ins;
        logic    init_walk;
        logic    step_cell;
        logic    take_hit;
        logic    fill_we;
        logic    slot_we;
        logic    out_load;
        logic    out_use_pend;
        status_t out_status;
        logic    out_last;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  in_grid;
        logic  sq_empty;
        logic  fill_full;
        logic  fill_zero;
        logic  slot_last;
        logic  cell_last;
        logic  n_limit;
        logic  pend_valid;
        logic  out_free;
        logic  clr_done;
    } sts_t;

endpackage

// ----- sv/fgbi_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module fgbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/fgbi_datapath.sv -----
// Datapath: cell arithmetic, grid walk registers, bucket memories and result register.
`timescale 1ns / 1ps

module fgbi_datapath #(
    parameter int GRID_DIM     = 64,
    parameter int CELL_SIZE    = 10,
    parameter int BUCKET_DEPTH = 4,
    parameter int RESULT_LIMIT = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [fgbi_pkg::S_TDATA_W-1:0]   s_tdata,
    input  fgbi_pkg::cmd_t                   cmd,
    output fgbi_pkg::sts_t                   sts,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fgbi_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);

    localparam int CELLS     = GRID_DIM * GRID_DIM;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int XW        = $clog2(GRID_DIM);
    localparam int SLOTS     = CELLS * BUCKET_DEPTH;
    localparam int SLOT_AW   = $clog2(SLOTS);
    localparam int FW        = $clog2(BUCKET_DEPTH + 1);
    localparam int NW        = $clog2(RESULT_LIMIT + 1);
    localparam int CW        = fgbi_pkg::COORD_W;
    localparam int QW        = fgbi_pkg::QUO_W;
    localparam int IW        = fgbi_pkg::INDEX_W;
    localparam int DIV_SHIFT = CW + $clog2(CELL_SIZE);
    localparam int PROD_W    = DIV_SHIFT + CW;
    localparam logic [fgbi_pkg::RECIP_W-1:0] DIV_RECIP =
        fgbi_pkg::RECIP_W'(((1 << DIV_SHIFT) + CELL_SIZE - 1) / CELL_SIZE);
    localparam logic signed [QW-1:0] GRID_MAX = QW'(GRID_DIM - 1);

    // Input request registers
    fgbi_pkg::mode_t            mode_reg;
    logic signed [CW-1:0]       u_reg;
    logic signed [CW-1:0]       v_reg;
    logic [IW-1:0]              idx_reg;
    logic [fgbi_pkg::RADIUS_W-1:0] radius_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= fgbi_pkg::mode_t'(s_tdata[1:0]);
            u_reg      <= s_tdata[13:2];
            v_reg      <= s_tdata[25:14];
            idx_reg    <= s_tdata[35:26];
            radius_reg <= s_tdata[46:36];
        end
    end

    // Division by the cell size as a reciprocal multiplication on magnitudes
    logic [CW-1:0]     u_mag, v_mag, r_mag;
    logic [PROD_W-1:0] prod_u_reg, prod_v_reg, prod_r_reg;

    assign u_mag = u_reg[CW-1] ? CW'(-u_reg) : CW'(u_reg);
    assign v_mag = v_reg[CW-1] ? CW'(-v_reg) : CW'(v_reg);
    assign r_mag = CW'(radius_reg);

    always_ff @(posedge aclk) begin
        prod_u_reg <= PROD_W'(u_mag) * PROD_W'(DIV_RECIP);
        prod_v_reg <= PROD_W'(v_mag) * PROD_W'(DIV_RECIP);
        prod_r_reg <= PROD_W'(r_mag) * PROD_W'(DIV_RECIP);
    end

    logic [CW-1:0]        q_u, q_v, q_r;
    logic signed [QW-1:0] q_u_s, q_v_s;
    logic signed [QW-1:0] cx_reg, cy_reg;
    logic [CW-1:0]        cr_reg;

    assign q_u   = prod_u_reg[DIV_SHIFT +: CW];
    assign q_v   = prod_v_reg[DIV_SHIFT +: CW];
    assign q_r   = prod_r_reg[DIV_SHIFT +: CW];
    assign q_u_s = signed'({2'b00, q_u});
    assign q_v_s = signed'({2'b00, q_v});

    always_ff @(posedge aclk) begin
        cx_reg <= u_reg[CW-1] ? -q_u_s : q_u_s;
        cy_reg <= v_reg[CW-1] ? -q_v_s : q_v_s;
        cr_reg <= q_r;
    end

    // Clamped square of cells around the point
    logic signed [QW-1:0] cr_s;
    logic signed [QW-1:0] x_lo_raw, x_hi_raw, y_lo_raw, y_hi_raw;
    logic signed [QW-1:0] x_lo_c, x_hi_c, y_lo_c, y_hi_c;
    logic [XW-1:0]        x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;
    logic                 sq_empty_reg, in_grid_reg;

    assign cr_s     = signed'({2'b00, cr_reg});
    assign x_lo_raw = cx_reg - cr_s;
    assign x_hi_raw = cx_reg + cr_s;
    assign y_lo_raw = cy_reg - cr_s;
    assign y_hi_raw = cy_reg + cr_s;
    assign x_lo_c   = (x_lo_raw < 0) ? '0 : x_lo_raw;
    assign x_hi_c   = (x_hi_raw > GRID_MAX) ? GRID_MAX : x_hi_raw;
    assign y_lo_c   = (y_lo_raw < 0) ? '0 : y_lo_raw;
    assign y_hi_c   = (y_hi_raw > GRID_MAX) ? GRID_MAX : y_hi_raw;

    always_ff @(posedge aclk) begin
        x_lo_reg     <= x_lo_c[XW-1:0];
        x_hi_reg     <= x_hi_c[XW-1:0];
        y_lo_reg     <= y_lo_c[XW-1:0];
        y_hi_reg     <= y_hi_c[XW-1:0];
        sq_empty_reg <= (x_hi_c < x_lo_c) || (y_hi_c < y_lo_c);
        in_grid_reg  <= (cx_reg >= 0) && (cx_reg <= GRID_MAX) &&
                        (cy_reg >= 0) && (cy_reg <= GRID_MAX);
    end

    // Walk position and cell address
    logic [XW-1:0]     x_reg, y_reg, x_next, y_next;
    logic [CELL_W-1:0] cell_reg, cell_next;

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        if (cmd.init_ins) begin
            x_next = cx_reg[XW-1:0];
            y_next = cy_reg[XW-1:0];
        end else if (cmd.init_walk) begin
            x_next = x_lo_reg;
            y_next = y_lo_reg;
        end else if (cmd.step_cell) begin
            if (y_reg == y_hi_reg) begin
                x_next = x_reg + XW'(1);
                y_next = y_lo_reg;
            end else begin
                y_next = y_reg + XW'(1);
            end
        end
        cell_next = CELL_W'(CELL_W'(x_next) * CELL_W'(GRID_DIM)) + CELL_W'(y_next);
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        cell_reg <= cell_next;
    end

    // Hit bookkeeping and clearing sweep counter
    logic [FW-1:0]     s_reg;
    logic [NW-1:0]     n_reg;
    logic [IW-1:0]     pend_reg;
    logic              pend_valid_reg;
    logic [CELL_W-1:0] clr_cnt_reg;
    logic [FW-1:0]     fill_rd;
    logic [IW-1:0]     slot_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            n_reg          <= '0;
            s_reg          <= '0;
            clr_cnt_reg    <= '0;
        end else begin
            if (cmd.load) begin
                pend_valid_reg <= 1'b0;
                n_reg          <= '0;
            end else if (cmd.take_hit) begin
                pend_valid_reg <= 1'b1;
                n_reg          <= n_reg + NW'(1);
            end
            if (cmd.init_walk || cmd.step_cell) begin
                s_reg <= '0;
            end else if (cmd.take_hit) begin
                s_reg <= s_reg + FW'(1);
            end
            if (cmd.clr_rst) begin
                clr_cnt_reg <= '0;
            end else if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + CELL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_hit) begin
            pend_reg <= slot_rd;
        end
    end

    // Bucket memories
    logic [SLOT_AW-1:0] slot_base;

    assign slot_base = SLOT_AW'(SLOT_AW'(cell_reg) * SLOT_AW'(BUCKET_DEPTH));

    fgbi_ram #(
        .WIDTH (FW),
        .DEPTH (CELLS)
    ) u_fill_ram (
        .aclk    (aclk),
        .wr_en   (cmd.fill_we || cmd.clr_step),
        .wr_addr (cmd.clr_step ? clr_cnt_reg : cell_reg),
        .wr_data (cmd.clr_step ? FW'(0) : fill_rd + FW'(1)),
        .rd_addr (cell_reg),
        .rd_data (fill_rd)
    );

    fgbi_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (cmd.slot_we),
        .wr_addr (slot_base + SLOT_AW'(fill_rd)),
        .wr_data (idx_reg),
        .rd_addr (slot_base + SLOT_AW'(s_reg)),
        .rd_data (slot_rd)
    );

    // Result register
    logic                    out_valid_reg;
    logic [IW-1:0]           out_index_reg;
    fgbi_pkg::status_t       out_status_reg;
    logic                    out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_index_reg  <= cmd.out_use_pend ? pend_reg : '0;
            out_status_reg <= cmd.out_status;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_status_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

    always_comb begin
        sts.mode       = mode_reg;
        sts.in_grid    = in_grid_reg;
        sts.sq_empty   = sq_empty_reg;
        sts.fill_full  = fill_rd >= FW'(BUCKET_DEPTH);
        sts.fill_zero  = fill_rd == '0;
        sts.slot_last  = (s_reg + FW'(1)) == fill_rd;
        sts.cell_last  = (x_reg == x_hi_reg) && (y_reg == y_hi_reg);
        sts.n_limit    = n_reg == NW'(RESULT_LIMIT);
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = !out_valid_reg || m_tready;
        sts.clr_done   = clr_cnt_reg == CELL_W'(CELLS - 1);
    end

endmodule

// ----- sv/fgbi_ctrl.sv -----
// Controller state machine sequencing insert, query and clear requests.
`timescale 1ns / 1ps

module fgbi_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  fgbi_pkg::sts_t  sts,
    output fgbi_pkg::cmd_t  cmd
);

    fgbi_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fgbi_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            fgbi_pkg::S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = fgbi_pkg::S_IDLE;
                end
            end
            fgbi_pkg::S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = fgbi_pkg::S_CALC1;
                end
            end
            fgbi_pkg::S_CALC1: begin
                case (sts.mode)
                    fgbi_pkg::MODE_INSERT, fgbi_pkg::MODE_QUERY: begin
                        state_next = fgbi_pkg::S_CALC2;
                    end
                    fgbi_pkg::MODE_CLEAR: begin
                        cmd.clr_rst = 1'b1;
                        state_next  = fgbi_pkg::S_CLEAR;
                    end
                    default: begin
                        state_next = fgbi_pkg::S_IDLE;
                    end
                endcase
            end
            fgbi_pkg::S_CALC2: begin
                state_next = fgbi_pkg::S_CALC3;
            end
            fgbi_pkg::S_CALC3: begin
                cmd.init_ins = 1'b1;
                state_next   = fgbi_pkg::S_DECIDE;
            end
            fgbi_pkg::S_DECIDE: begin
                if (sts.mode == fgbi_pkg::MODE_INSERT) begin
                    state_next = sts.in_grid ? fgbi_pkg::S_INS_FILL
                                             : fgbi_pkg::S_INS_OUTSIDE;
                end else if (sts.sq_empty) begin
                    state_next = fgbi_pkg::S_Q_END;
                end else begin
                    cmd.init_walk = 1'b1;
                    state_next    = fgbi_pkg::S_Q_ADDR;
                end
            end
            fgbi_pkg::S_INS_OUTSIDE: begin
                if (sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = fgbi_pkg::ST_OUTSIDE;
                    cmd.out_last   = 1'b1;
                    state_next     = fgbi_pkg::S_IDLE;
                end
            end
            fgbi_pkg::S_INS_FILL: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    if (sts.fill_full) begin
                        cmd.out_status = fgbi_pkg::ST_FULL;
                    end else begin
                        cmd.out_status = fgbi_pkg::ST_STORED;
                        cmd.fill_we    = 1'b1;
                        cmd.slot_we    = 1'b1;
                    end
                    state_next = fgbi_pkg::S_IDLE;
                end
            end
            fgbi_pkg::S_Q_ADDR: begin
                state_next = fgbi_pkg::S_Q_FILL;
            end
            fgbi_pkg::S_Q_FILL: begin
                if (!sts.fill_zero) begin
                    state_next = fgbi_pkg::S_Q_SLOT;
                end else if (sts.cell_last) begin
                    state_next = fgbi_pkg::S_Q_END;
                end else begin
                    cmd.step_cell = 1'b1;
                    state_next    = fgbi_pkg::S_Q_ADDR;
                end
            end
            fgbi_pkg::S_Q_SLOT: begin
                if (sts.n_limit) begin
                    state_next = fgbi_pkg::S_Q_TRUNC;
                end else if (!sts.pend_valid || sts.out_free) begin
                    // The held hit goes out now that a newer one follows it.
                    cmd.take_hit     = 1'b1;
                    cmd.out_load     = sts.pend_valid;
                    cmd.out_use_pend = 1'b1;
                    cmd.out_status   = fgbi_pkg::ST_HIT;
                    if (!sts.slot_last) begin
                        state_next = fgbi_pkg::S_Q_SADDR;
                    end else if (sts.cell_last) begin
                        state_next = fgbi_pkg::S_Q_END;
                    end else begin
                        cmd.step_cell = 1'b1;
                        state_next    = fgbi_pkg::S_Q_ADDR;
                    end
                end
            end
            fgbi_pkg::S_Q_SADDR: begin
                state_next = fgbi_pkg::S_Q_SLOT;
            end
            fgbi_pkg::S_Q_END: begin
                if (sts.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_last     = 1'b1;
                    cmd.out_use_pend = sts.pend_valid;
                    cmd.out_status   = sts.pend_valid ? fgbi_pkg::ST_HIT
                                                      : fgbi_pkg::ST_EMPTY;
                    state_next       = fgbi_pkg::S_IDLE;
                end
            end
            fgbi_pkg::S_Q_TRUNC: begin
                if (sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_status = fgbi_pkg::ST_TRUNC;
                    state_next     = fgbi_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fgbi_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/feature_grid_bucket_index.sv -----
// Top level of the uniform-grid feature bucket index.
// Insert: stores the index in its cell, or reports the point outside or the cell full.
// Query: sets up, walks each cell of the square and reads each stored hit of a cell,
// then gives the final result; each request is finished before the next one is taken.
// Clear: GRID_DIM*GRID_DIM cells, one cell a cycle, and gives no result.
// Reset (synchronous, active low) starts the same clearing pass over GRID_DIM*GRID_DIM
// cells, during which s_tready stays low.
`timescale 1ns / 1ps

module feature_grid_bucket_index_core #(
    parameter int GRID_DIM     = 64,
    parameter int CELL_SIZE    = 10,
    parameter int BUCKET_DEPTH = 4,
    parameter int RESULT_LIMIT = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mode[1:0], u[13:2], v[25:14], point_index[35:26], radius[46:36], zero fill
    input  logic [fgbi_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found_index[9:0], status[12:10], zero fill
    output logic [fgbi_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);

    fgbi_pkg::cmd_t cmd;
    fgbi_pkg::sts_t sts;

    fgbi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fgbi_datapath #(
        .GRID_DIM     (GRID_DIM),
        .CELL_SIZE    (CELL_SIZE),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .RESULT_LIMIT (RESULT_LIMIT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result register loaded while a result is still waiting");

    a_slot_with_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.slot_we |-> (cmd.fill_we && cmd.out_load && !sts.fill_full))
        else $error("slot written without a matching fill update and result");

    a_hit_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_hit |-> !sts.n_limit)
        else $error("hit taken beyond the result limit");

    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !cmd.out_load && !s_tready)
        else $error("request accepted while the previous one was still in work");
`endif

endmodule

// ----- tb/tb_feature_grid_bucket_index_core.sv -----
// Self-checking testbench for the feature grid bucket index core.
`timescale 1ns / 1ps

module tb_feature_grid_bucket_index_core;

    localparam int GRID            = 64;
    localparam int CELL            = 10;
    localparam int DEPTH           = 4;
    localparam int LIMIT           = 64;
    localparam int RANDOM_REQUESTS = 182;
    localparam int DRAIN_CYCLES    = GRID * GRID + 200;
    localparam int DIRECTED_ROWS   = 22;
    localparam int IDX_W           = fgbi_pkg::INDEX_W;
    localparam int ST_W            = fgbi_pkg::STATUS_W;
    localparam int SD_W            = fgbi_pkg::S_TDATA_W;

    typedef struct {
        logic [IDX_W-1:0]  found;
        fgbi_pkg::status_t status;
        logic              last;
    } grid_reply_t;

    typedef struct {
        fgbi_pkg::mode_t   md;
        int                u;
        int                v;
        int                pidx;
        int                radius;
        logic              fixed;
        fgbi_pkg::status_t status;
    } directed_row_t;

    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic [SD_W-1:0]                    s_tdata  = '0;
    logic                               s_tready;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [fgbi_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                               m_tlast;

    int                 fill_count [GRID*GRID];
    logic [IDX_W-1:0]   slot_store [GRID*GRID*DEPTH];
    grid_reply_t        fresh_replies[$];
    grid_reply_t        due_replies[$];

    int errors       = 0;
    int checked      = 0;
    int truncations  = 0;
    int full_replies = 0;
    int empty_lists  = 0;
    int inserts      = 0;
    int queries      = 0;
    int clears       = 0;
    bit calm         = 1'b0;
    int base_u;
    int base_v;

    // Rows marked fixed give exactly one reply with their status, found_index zero and last set.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{fgbi_pkg::MODE_INSERT,      0,     0,    0,    0, 1'b1, fgbi_pkg::ST_STORED},
        '{fgbi_pkg::MODE_INSERT,     -9,    -9, 1023,    0, 1'b1, fgbi_pkg::ST_STORED},
        '{fgbi_pkg::MODE_INSERT,    -10,     0,    5,    0, 1'b1, fgbi_pkg::ST_OUTSIDE},
        '{fgbi_pkg::MODE_INSERT,      0, -2048,    5, 2047, 1'b1, fgbi_pkg::ST_OUTSIDE},
        '{fgbi_pkg::MODE_INSERT,   2047,  2047,    5,    0, 1'b1, fgbi_pkg::ST_OUTSIDE},
        '{fgbi_pkg::MODE_INSERT,    640,     0,    5,    0, 1'b1, fgbi_pkg::ST_OUTSIDE},
        '{fgbi_pkg::MODE_INSERT,    639,   639,  512,    0, 1'b1, fgbi_pkg::ST_STORED},
        '{fgbi_pkg::MODE_INSERT,      5,     9,  341,    0, 1'b1, fgbi_pkg::ST_STORED},
        '{fgbi_pkg::MODE_INSERT,      9,     0,  682,    0, 1'b1, fgbi_pkg::ST_STORED},
        '{fgbi_pkg::MODE_INSERT,      0,     0,    7,    0, 1'b1, fgbi_pkg::ST_FULL},
        '{fgbi_pkg::MODE_QUERY,       0,     0,    0,    0, 1'b0, fgbi_pkg::ST_HIT},
        '{fgbi_pkg::MODE_QUERY,     639,   639, 1023,    9, 1'b0, fgbi_pkg::ST_HIT},
        '{fgbi_pkg::MODE_QUERY,   -2048, -2048,    0,    0, 1'b1, fgbi_pkg::ST_EMPTY},
        '{fgbi_pkg::MODE_QUERY,    2047,     0,    0, 2047, 1'b0, fgbi_pkg::ST_HIT},
        '{fgbi_pkg::MODE_QUERY,    2047,  2047,    0,    0, 1'b1, fgbi_pkg::ST_EMPTY},
        '{fgbi_pkg::MODE_QUERY,     320,   320,    0,    9, 1'b1, fgbi_pkg::ST_EMPTY},
        '{fgbi_pkg::MODE_UNUSED,   -555,   777,  999, 1234, 1'b0, fgbi_pkg::ST_HIT},
        '{fgbi_pkg::MODE_QUERY,   -2048,  2047,    0, 2047, 1'b0, fgbi_pkg::ST_HIT},
        '{fgbi_pkg::MODE_CLEAR,    1234, -1234,  321,  555, 1'b0, fgbi_pkg::ST_HIT},
        '{fgbi_pkg::MODE_QUERY,       0,     0,    0, 2047, 1'b1, fgbi_pkg::ST_EMPTY},
        '{fgbi_pkg::MODE_INSERT,      0,     0,    1,    0, 1'b1, fgbi_pkg::ST_STORED},
        '{fgbi_pkg::MODE_QUERY,       0,     0,    0,    0, 1'b0, fgbi_pkg::ST_HIT}
    };

    feature_grid_bucket_index_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("Timeout with %0d replies outstanding.", due_replies.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void queue_fresh(input grid_reply_t r);
        fresh_replies.insert(fresh_replies.size(), r);
    endfunction

    function automatic void queue_due(input grid_reply_t r);
        due_replies.insert(due_replies.size(), r);
    endfunction

    function automatic logic [SD_W-1:0] pack_request(input fgbi_pkg::mode_t md, input int u,
                                                      input int v, input int pidx,
                                                      input int radius);
        logic [SD_W-1:0] word;
        word        = '0;
        word[1:0]   = md;
        word[13:2]  = u[fgbi_pkg::COORD_W-1:0];
        word[25:14] = v[fgbi_pkg::COORD_W-1:0];
        word[35:26] = pidx[IDX_W-1:0];
        word[46:36] = radius[fgbi_pkg::RADIUS_W-1:0];
        return word;
    endfunction

    function automatic int pick_base();
        int sel;
        sel = $urandom_range(0, 2);
        return (sel == 0) ? 0 : (sel == 1) ? 30 : GRID - 5;
    endfunction

    // A pixel coordinate inside a five-cell strip, reaching negative pixels at cell zero.
    function automatic int cluster_coord(input int base);
        int c;
        c = base + $urandom_range(0, 4);
        if (c == 0 && $urandom_range(0, 1) == 1)
            return -int'($urandom_range(0, CELL - 1));
        return c * CELL + int'($urandom_range(0, CELL - 1));
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    // Works out the replies to one request and updates the grid copy.
    function automatic void model_grid(input logic [SD_W-1:0] req);
        fgbi_pkg::mode_t    md;
        int                 cx, cy, cr, x0, x1, y0, y1, x, y, s, bucket, n;
        logic [IDX_W-1:0]   pidx;
        fresh_replies.delete();
        md   = fgbi_pkg::mode_t'(req[1:0]);
        cx   = int'($signed(req[13:2])) / CELL;
        cy   = int'($signed(req[25:14])) / CELL;
        pidx = req[35:26];
        cr   = int'(req[46:36]) / CELL;
        case (md)
            fgbi_pkg::MODE_INSERT: begin
                if (cx < 0 || cx >= GRID || cy < 0 || cy >= GRID) begin
                    queue_fresh('{'0, fgbi_pkg::ST_OUTSIDE, 1'b1});
                end else begin
                    bucket = cx * GRID + cy;
                    if (fill_count[bucket] >= DEPTH) begin
                        queue_fresh('{'0, fgbi_pkg::ST_FULL, 1'b1});
                    end else begin
                        slot_store[bucket * DEPTH + fill_count[bucket]] = pidx;
                        fill_count[bucket]++;
                        queue_fresh('{'0, fgbi_pkg::ST_STORED, 1'b1});
                    end
                end
            end
            fgbi_pkg::MODE_QUERY: begin
                x0 = (cx - cr < 0) ? 0 : cx - cr;
                y0 = (cy - cr < 0) ? 0 : cy - cr;
                x1 = (cx + cr > GRID - 1) ? GRID - 1 : cx + cr;
                y1 = (cy + cr > GRID - 1) ? GRID - 1 : cy + cr;
                n  = 0;
                for (x = x0; x <= x1; x++) begin
                    for (y = y0; y <= y1; y++) begin
                        bucket = x * GRID + y;
                        for (s = 0; s < fill_count[bucket]; s++) begin
                            if (n == LIMIT) begin
                                fresh_replies[LIMIT-1] = '{'0, fgbi_pkg::ST_TRUNC, 1'b1};
                                return;
                            end
                            queue_fresh('{slot_store[bucket * DEPTH + s], fgbi_pkg::ST_HIT,
                                          1'b0});
                            n++;
                        end
                    end
                end
                if (n == 0)
                    queue_fresh('{'0, fgbi_pkg::ST_EMPTY, 1'b1});
                else
                    fresh_replies[n-1].last = 1'b1;
            end
            fgbi_pkg::MODE_CLEAR: begin
                foreach (fill_count[c])
                    fill_count[c] = 0;
            end
            default: ;
        endcase
    endfunction

    task automatic issue_request(input logic [SD_W-1:0] req, input logic fixed,
                                 input fgbi_pkg::status_t fixed_status);
        while (!calm && $urandom_range(0, 99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        @(posedge aclk);
        while (s_tready !== 1'b1)
            @(posedge aclk);
        model_grid(req);
        if (fixed)
            queue_due('{'0, fixed_status, 1'b1});
        else
            foreach (fresh_replies[i])
                queue_due(fresh_replies[i]);
        case (fgbi_pkg::mode_t'(req[1:0]))
            fgbi_pkg::MODE_INSERT: inserts++;
            fgbi_pkg::MODE_QUERY:  queries++;
            fgbi_pkg::MODE_CLEAR:  clears++;
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        grid_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_replies.size() == 0) begin
                errors++;
                $display("%0t: reply with none expected, found=%0d status=%0d last=%0b",
                         $time, m_tdata[IDX_W-1:0], m_tdata[IDX_W+ST_W-1:IDX_W],
                         m_tlast);
            end else begin
                want = due_replies.pop_front();
                checked++;
                if (m_tdata[IDX_W-1:0] !== want.found
                        || m_tdata[IDX_W+ST_W-1:IDX_W] !== want.status
                        || m_tlast !== want.last) begin
                    errors++;
                    $display("%0t: expected found=%0d status=%0d last=%0b, got found=%0d status=%0d last=%0b",
                             $time, want.found, want.status, want.last, m_tdata[IDX_W-1:0],
                             m_tdata[IDX_W+ST_W-1:IDX_W], m_tlast);
                end
                case (want.status)
                    fgbi_pkg::ST_TRUNC: truncations++;
                    fgbi_pkg::ST_FULL:  full_replies++;
                    fgbi_pkg::ST_EMPTY: empty_lists++;
                    default: ;
                endcase
            end
        end
        m_tready <= calm || ($urandom_range(0, 99) >= 36);
    end

    initial begin
        logic [SD_W-1:0] req;
        int              pick;
        int              random_sent;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            req = pack_request(directed_rows[k].md, directed_rows[k].u, directed_rows[k].v,
                               directed_rows[k].pidx, directed_rows[k].radius);
            issue_request(req, directed_rows[k].fixed, directed_rows[k].status);
        end

        // Most inserts and queries crowd into a five-by-five patch of cells, picked anew at each
        // clear, so that buckets fill up and wide queries run into the result limit; clears come early only.
        base_u      = pick_base();
        base_v      = pick_base();
        random_sent = 0;
        while (random_sent < RANDOM_REQUESTS) begin
            calm = (random_sent >= 90 && random_sent < 140);
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                req = pack_request(fgbi_pkg::MODE_UNUSED, $urandom, $urandom, $urandom,
                                   $urandom);
                issue_request(req, 1'b0, fgbi_pkg::ST_HIT);
            end else begin
                if (pick < 7 && random_sent < 80) begin
                    req    = pack_request(fgbi_pkg::MODE_CLEAR, $urandom, $urandom, $urandom,
                                          $urandom);
                    base_u = pick_base();
                    base_v = pick_base();
                end else if (pick < 55) begin
                    req = pack_request(fgbi_pkg::MODE_INSERT, cluster_coord(base_u),
                                       cluster_coord(base_v), $urandom_range(0, 1023),
                                       $urandom_range(0, 2047));
                end else if (pick < 65) begin
                    req = pack_request(fgbi_pkg::MODE_INSERT, any_coord(), any_coord(),
                                       $urandom_range(0, 1023), $urandom_range(0, 2047));
                end else if (pick < 92) begin
                    req = pack_request(fgbi_pkg::MODE_QUERY, cluster_coord(base_u),
                                       cluster_coord(base_v), $urandom_range(0, 1023),
                                       $urandom_range(0, 35));
                end else begin
                    req = pack_request(fgbi_pkg::MODE_QUERY, any_coord(), any_coord(),
                                       $urandom_range(0, 1023), $urandom_range(0, 2047));
                end
                issue_request(req, 1'b0, fgbi_pkg::ST_HIT);
                random_sent++;
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (due_replies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run sent %0d inserts, %0d queries and %0d clears with random stalls.",
                 inserts, queries, clears);
        $display("%0d replies checked: %0d truncated lists, %0d full cells, %0d empty queries.",
                 checked, truncations, full_replies, empty_lists);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
